// File: sv/sta_pkg.sv
// Shared types, register codes and helpers for the swizzled texel address unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
package sta_pkg;

   localparam int ADDR_BITS      = 32;
   localparam int PITCH_BITS     = 16;
   localparam int BPT_BITS       = 3;
   localparam int SIZE_BITS      = 13;
   localparam int LOG_BITS       = 4;
   localparam int MAX_LOG        = 12;
   localparam int POS_BITS       = 6;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BASE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PITCH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BPT    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEPTH  = 3'd5;

   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_2D     = 2'd1;
   localparam logic [1:0] MODE_3D     = 2'd2;

   typedef logic [LOG_BITS-1:0] log_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  base;
      logic [PITCH_BITS-1:0] pitch;
      logic [BPT_BITS-1:0]   bpt;
      logic [SIZE_BITS-1:0]  width;
      logic [SIZE_BITS-1:0]  height;
      logic [SIZE_BITS-1:0]  depth;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      log_type    k;
      log_type    nb_x;
      log_type    nb_y;
      log_type    nb_z;
   } ctl_type;

   // Position of the highest set bit; zero and one both give zero.
   function automatic log_type floor_log2(input logic [SIZE_BITS-1:0] v);
      log_type r;
      r = '0;
      for (int i = 1; i < SIZE_BITS; i++) begin
         if (v[i]) begin
            r = LOG_BITS'(i);
         end
      end
      return r;
   endfunction

endpackage

// File: sv/sta_decode.sv
// First pipeline stage: layout selection, log2 of the surface sizes, coordinate capture.
// Depends on sta_pkg for the configuration and control structs.
module sta_decode #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sta_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   input  logic [COORD_BITS-1:0] in_z,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [COORD_BITS-1:0] out_x,
   output logic [COORD_BITS-1:0] out_y,
   output logic [COORD_BITS-1:0] out_z,
   output sta_pkg::ctl_type      out_ctl
);

   logic                           valid_ff;
   logic [COORD_BITS-1:0]          x_ff, y_ff, z_ff;
   sta_pkg::ctl_type               ctl_ff, ctl_in;
   logic [sta_pkg::SIZE_BITS-1:0]  min_size;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      min_size = (cfg.width < cfg.height) ? cfg.width : cfg.height;
      if (cfg.pitch != '0) begin
         ctl_in.mode = sta_pkg::MODE_LINEAR;
      end else if (cfg.depth <= sta_pkg::SIZE_BITS'(1)) begin
         ctl_in.mode = sta_pkg::MODE_2D;
      end else begin
         ctl_in.mode = sta_pkg::MODE_3D;
      end
      ctl_in.k    = sta_pkg::floor_log2(min_size);
      ctl_in.nb_x = sta_pkg::floor_log2(cfg.width);
      ctl_in.nb_y = sta_pkg::floor_log2(cfg.height);
      ctl_in.nb_z = sta_pkg::floor_log2(cfg.depth);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff   <= in_x;
         y_ff   <= in_y;
         z_ff   <= in_z;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_ctl   = ctl_ff;

endmodule

// File: sv/sta_offset.sv
// Second and third pipeline stages: products, Morton spread and 3D interleave, then
// the texel offset of the selected layout. Depends on sta_pkg.
module sta_offset #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sta_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COORD_BITS-1:0]         in_x,
   input  logic [COORD_BITS-1:0]         in_y,
   input  logic [COORD_BITS-1:0]         in_z,
   input  sta_pkg::ctl_type              in_ctl,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_linear,
   output logic [sta_pkg::ADDR_BITS-1:0] out_offset
);

   localparam int AW = sta_pkg::ADDR_BITS;

   logic                  s2_valid_ff, s3_valid_ff, ready2, ready3;
   logic [1:0]            mode2_ff;
   sta_pkg::log_type      k2_ff;
   logic [AW-1:0]         lin_y_ff, lin_y_in, lin_x_ff, lin_x_in;
   logic [AW-1:0]         morton_ff, morton_in, tile_prod_ff, tile_prod_in;
   logic [AW-1:0]         interleave_ff, interleave_in;
   logic [COORD_BITS-1:0] tile_x_ff, tile_x_in;
   logic [COORD_BITS-1:0] km, xm, ym, tile_y;
   logic [sta_pkg::SIZE_BITS-1:0] tiles_x;
   logic [AW-1:0]         texel_off_ff, texel_off_in, tile_sum;
   logic                  linear_ff;
   logic [AW-1:0]         coord_ext [3];
   sta_pkg::log_type      nb [3];

   assign ready3   = !s3_valid_ff || out_ready;
   assign ready2   = !s2_valid_ff || ready3;
   assign in_ready = ready2;

   always_comb begin
      lin_y_in = AW'(in_y) * AW'(cfg.pitch);
      lin_x_in = AW'(in_x) * AW'(cfg.bpt);

      km = (COORD_BITS'(1) << in_ctl.k) - COORD_BITS'(1);
      xm = in_x & km;
      ym = in_y & km;
      morton_in = '0;
      for (int i = 0; i < COORD_BITS; i++) begin
         morton_in[2*i]   = xm[i];
         morton_in[2*i+1] = ym[i];
      end
      tiles_x      = cfg.width >> in_ctl.k;
      tile_y       = in_y >> in_ctl.k;
      tile_x_in    = in_x >> in_ctl.k;
      tile_prod_in = AW'(tile_y) * AW'(tiles_x);
   end

   // Round-robin interleave: within each round the bit of each dimension that still
   // has bits left goes to the next free position.
   always_comb begin
      logic [sta_pkg::POS_BITS-1:0] pos;
      coord_ext[0]  = AW'(in_x);
      coord_ext[1]  = AW'(in_y);
      coord_ext[2]  = AW'(in_z);
      nb[0]         = in_ctl.nb_x;
      nb[1]         = in_ctl.nb_y;
      nb[2]         = in_ctl.nb_z;
      interleave_in = '0;
      for (int r = 0; r < sta_pkg::MAX_LOG; r++) begin
         for (int d = 0; d < 3; d++) begin
            pos = '0;
            for (int e = 0; e < 3; e++) begin
               if (sta_pkg::LOG_BITS'(r) < nb[e]) begin
                  pos = pos + sta_pkg::POS_BITS'(r);
               end else begin
                  pos = pos + sta_pkg::POS_BITS'(nb[e]);
               end
               if (e < d && sta_pkg::LOG_BITS'(r) < nb[e]) begin
                  pos = pos + sta_pkg::POS_BITS'(1);
               end
            end
            if (sta_pkg::LOG_BITS'(r) < nb[d] && pos < sta_pkg::POS_BITS'(AW)) begin
               interleave_in[pos[4:0]] = coord_ext[d][r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && in_valid) begin
         mode2_ff      <= in_ctl.mode;
         k2_ff         <= in_ctl.k;
         lin_y_ff      <= lin_y_in;
         lin_x_ff      <= lin_x_in;
         morton_ff     <= morton_in;
         tile_prod_ff  <= tile_prod_in;
         tile_x_ff     <= tile_x_in;
         interleave_ff <= interleave_in;
      end
   end

   always_comb begin
      tile_sum = tile_prod_ff + AW'(tile_x_ff);
      case (mode2_ff)
         sta_pkg::MODE_LINEAR: begin
            texel_off_in = lin_y_ff + lin_x_ff;
         end
         sta_pkg::MODE_2D: begin
            texel_off_in = morton_ff + (tile_sum << {1'b0, k2_ff, 1'b0});
         end
         default: begin
            texel_off_in = interleave_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ready3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && s2_valid_ff) begin
         texel_off_ff <= texel_off_in;
         linear_ff    <= (mode2_ff == sta_pkg::MODE_LINEAR);
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_linear = linear_ff;
   assign out_offset = texel_off_ff;

endmodule

// File: sv/swizzled_texel_address_unit.sv
// Top level of the swizzled texel address unit: configuration registers, final scaling
// stage and output register. Depends on sta_pkg, sta_decode and sta_offset.
//
// Each request beat carries a texel coordinate (x, y, z); each response beat carries the
// byte address of that texel in the surface described by the configuration registers,
// in linear, 2D Morton or 3D interleaved layout, modulo 2^32.
// Registers are written through csr_wr_en / csr_index / csr_wr_data; the user must write
// them only while no beat is in flight, as the block does not enforce this; indexes past the register list are ignored.
// The pipeline has four register stages: decode, products and bit interleave, layout
// offset, and base plus texel-size scaling into the output register. One beat per cycle
// is sustained while the receiver is ready.
// Each stage takes a new beat when it is empty or its successor takes its beat, so a
// stalled receiver holds the response in place, bubbles still fill, and req_tready
// falls only once every stage holds a beat.
// Reset clears all stage valid bits and loads the register defaults: base 0, pitch 0,
// four bytes per texel and a 1 x 1 x 1 surface.
module swizzled_texel_address_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // coord_x, coord_y, coord_z from bit 0 up, zero padding above.
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // byte_address.
   output logic [sta_pkg::ADDR_BITS-1:0]             rsp_tdata,
   input  logic                                      csr_wr_en,
   input  logic [sta_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [sta_pkg::ADDR_BITS-1:0]             csr_wr_data
);

   localparam int AW = sta_pkg::ADDR_BITS;

   sta_pkg::cfg_type      cfg_ff, cfg_in;
   logic                  dec_valid, dec_ready, off_valid, off_ready, off_linear;
   logic [COORD_BITS-1:0] dec_x, dec_y, dec_z;
   sta_pkg::ctl_type      dec_ctl;
   logic [AW-1:0]         off_offset, addr_in, addr_ff;
   logic                  rsp_valid_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sta_pkg::REG_BASE:   cfg_in.base   = csr_wr_data;
            sta_pkg::REG_PITCH:  cfg_in.pitch  = csr_wr_data[sta_pkg::PITCH_BITS-1:0];
            sta_pkg::REG_BPT:    cfg_in.bpt    = csr_wr_data[sta_pkg::BPT_BITS-1:0];
            sta_pkg::REG_WIDTH:  cfg_in.width  = csr_wr_data[sta_pkg::SIZE_BITS-1:0];
            sta_pkg::REG_HEIGHT: cfg_in.height = csr_wr_data[sta_pkg::SIZE_BITS-1:0];
            sta_pkg::REG_DEPTH:  cfg_in.depth  = csr_wr_data[sta_pkg::SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base   <= '0;
         cfg_ff.pitch  <= '0;
         cfg_ff.bpt    <= sta_pkg::BPT_BITS'(4);
         cfg_ff.width  <= sta_pkg::SIZE_BITS'(1);
         cfg_ff.height <= sta_pkg::SIZE_BITS'(1);
         cfg_ff.depth  <= sta_pkg::SIZE_BITS'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sta_decode #(
      .COORD_BITS(COORD_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[COORD_BITS-1:0]),
      .in_y      (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .in_z      (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_x     (dec_x),
      .out_y     (dec_y),
      .out_z     (dec_z),
      .out_ctl   (dec_ctl)
   );

   sta_offset #(
      .COORD_BITS(COORD_BITS)
   ) u_offset (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (dec_valid),
      .in_ready   (dec_ready),
      .in_x       (dec_x),
      .in_y       (dec_y),
      .in_z       (dec_z),
      .in_ctl     (dec_ctl),
      .out_valid  (off_valid),
      .out_ready  (off_ready),
      .out_linear (off_linear),
      .out_offset (off_offset)
   );

   assign off_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (off_linear) begin
         addr_in = cfg_ff.base + off_offset;
      end else begin
         addr_in = cfg_ff.base + off_offset * AW'(cfg_ff.bpt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (off_ready) begin
         rsp_valid_ff <= off_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (off_ready && off_valid) begin
         addr_ff <= addr_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = addr_ff;

endmodule
